// File: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define IPM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define IPM_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication checked outside reset
`define IPM_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: sv/ipm_pkg.sv
// types and constants of the interval paint map
package ipm_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int MAX_SOURCES = 16;
  localparam int POS_BITS    = 40;

  localparam int SRC_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int MODE_W   = 2;
  localparam int SCNT_W   = 5;
  localparam int FLEN_W   = 40;
  // counts that may run one past a full table
  localparam int CNT_W    = $clog2(MAX_ENTRIES + 2);
  // walk index over the table, up to MAX_ENTRIES
  localparam int ENT_W    = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_PAINT  = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_FULL   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_BAD_SRC  = 3'd1,
    STAT_ZERO_LEN = 3'd2,
    STAT_END_OVF  = 3'd3,
    STAT_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [POS_BITS-1:0] position;
    logic [POS_BITS-1:0] span;
    logic [SRC_W-1:0]    source_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SRC_W-1:0]    found_source;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    logic [POS_BITS-1:0] start;
    logic [POS_BITS-1:0] length;
    logic [SRC_W-1:0]    source;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_SHIFT  = 2'd1,
    CELL_LOAD   = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [SRC_W-1:0]    drop_src;
    logic [POS_BITS-1:0] query;
  } cell_ctrl_t;

endpackage

// File: sv/ipm_cell.sv
// one interval slot: shifts to its neighbor, loads, remaps its source, matches a query
module ipm_cell (
  input  logic               clk,
  input  logic               rst,
  input  ipm_pkg::cell_ctrl_t ctrl,
  input  ipm_pkg::entry_t    nbr,
  input  ipm_pkg::entry_t    load,
  output ipm_pkg::entry_t    ent,
  output logic               hit
);
  import ipm_pkg::*;

  logic [POS_BITS:0] ent_end;
  logic              match;

  always_comb begin
    ent_end = {1'b0, ent.start} + {1'b0, ent.length};
    match   = ent.valid && (ctrl.query >= ent.start) && ({1'b0, ctrl.query} < ent_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      hit       <= 1'b0;
    end else begin
      hit <= match;
      case (ctrl.op)
        CELL_SHIFT: ent <= nbr;
        CELL_LOAD:  ent <= load;
        CELL_REMOVE: begin
          if (ent.valid && ent.source == ctrl.drop_src) begin
            ent.source <= '0;
          end else if (ent.valid && ent.source > ctrl.drop_src) begin
            ent.source <= ent.source - 1'b1;
          end
        end
        default: ent <= ent;
      endcase
    end
  end

endmodule

// File: sv/ipm_merge.sv
// joins touching pieces of the same source and hands finished intervals to the build row
module ipm_merge (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            flush,
  input  ipm_pkg::entry_t piece,
  output logic            push,
  output ipm_pkg::entry_t push_ent
);
  import ipm_pkg::*;

  entry_t              last;
  logic [POS_BITS-1:0] last_end;
  logic                join_ok;

  always_comb begin
    join_ok  = last.valid && piece.valid && (last_end == piece.start) &&
               (last.source == piece.source);
    push     = flush || (piece.valid && !join_ok && last.valid);
    push_ent = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last.valid <= 1'b0;
    end else if (start || flush) begin
      last.valid <= 1'b0;
    end else if (piece.valid) begin
      if (join_ok) begin
        last.length <= last.length + piece.length;
      end else begin
        last <= piece;
      end
      // a joined piece starts where the held one ends, so the new end is the same sum
      last_end <= piece.start + piece.length;
    end
  end

endmodule

// File: sv/interval_paint_map_top.sv
// Interval paint map: a row of MAX_ENTRIES cells holds sorted, non-overlapping intervals,
// each a start, a length and a source index. One item is taken at a time. A lookup result
// is set by the registered match in every cell and the source reduction. Remove-source and
// reset-to-full update all cells together. A paint walks the table through the head cell
// of a rotating ring, four steps per held interval and one per empty slot, feeding split
// pieces to a merge unit that fills a second row of cells, which is then realigned and
// copied back. A paint rejected on its fields goes straight to the result. A result waits
// in an output register, so the next item may come in while it is not yet taken.
`include "assert_macros.svh"

module interval_paint_map_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  ipm_pkg::req_t          req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output ipm_pkg::rsp_t          rsp,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);
  import ipm_pkg::*;

  localparam logic REG_SOURCE_COUNT  = 1'b0;
  localparam logic REG_FOLDER_LENGTH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_LOOK_SUM, ST_REMOVE, ST_FULL,
    ST_PAINT, ST_DRAIN, ST_FLUSH, ST_COMMIT, ST_DONE
  } state_t;

  state_t              state;
  logic [SCNT_W-1:0]   source_count;
  logic [FLEN_W-1:0]   folder_length;
  logic [ENT_W-1:0]    ent;
  logic [1:0]          phase;
  logic                placed;
  logic [POS_BITS:0]   e_reg;
  logic [POS_BITS-1:0] pos_r;
  logic [POS_BITS-1:0] span_r;
  logic [POS_BITS-1:0] pend;
  logic [SRC_W-1:0]    src_r;
  entry_t              piece;
  logic [CNT_W-1:0]    push_cnt;
  logic [CNT_W-1:0]    m_cnt;
  logic [CNT_W-1:0]    held;
  status_t             res_status;
  logic [SRC_W-1:0]    res_found;

  entry_t              tbl   [MAX_ENTRIES];
  entry_t              bld   [MAX_ENTRIES];
  entry_t              tbl_load [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] hit;
  logic [MAX_ENTRIES-1:0] bld_hit;
  logic [MAX_ENTRIES-1:0] vmask;
  cell_ctrl_t          tbl_ctrl;
  cell_ctrl_t          bld_ctrl;
  entry_t              head;
  entry_t              full_ent;
  entry_t              new_piece;
  logic                ovl;
  logic                rotate;
  logic                commit_ok;
  logic                mstart;
  logic                mflush;
  logic                mpush;
  entry_t              mpush_ent;
  logic [SRC_W-1:0]    found;
  logic [POS_BITS:0]   req_end;
  logic                bad_src;
  logic                cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3])
      REG_SOURCE_COUNT:  prdata = 64'(source_count);
      REG_FOLDER_LENGTH: prdata = 64'(folder_length);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_count  <= '0;
      folder_length <= '0;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_SOURCE_COUNT:  source_count  <= pwdata[SCNT_W-1:0];
        REG_FOLDER_LENGTH: folder_length <= pwdata[FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // combinational control
  assign req_ready = (state == ST_IDLE);
  assign head      = tbl[0];

  always_comb begin
    req_end   = {1'b0, req.position} + {1'b0, req.span};
    bad_src   = ({1'b0, req.source_index} >= source_count) ||
                (32'(req.source_index) >= MAX_SOURCES);
    ovl       = (e_reg > {1'b0, pos_r}) && (head.start < pend);
    rotate    = (state == ST_PAINT) && (32'(ent) != MAX_ENTRIES) &&
                (!head.valid || phase == 2'd3);
    commit_ok = (state == ST_COMMIT) && (32'(m_cnt) <= MAX_ENTRIES);
    mstart    = req_valid && req_ready;
    mflush    = (state == ST_FLUSH);

    new_piece.valid  = 1'b1;
    new_piece.start  = pos_r;
    new_piece.length = span_r;
    new_piece.source = src_r;

    full_ent.valid  = (folder_length != '0);
    full_ent.start  = '0;
    full_ent.length = folder_length;
    full_ent.source = '0;

    tbl_ctrl.drop_src = src_r;
    tbl_ctrl.query    = pos_r;
    if (rotate) begin
      tbl_ctrl.op = CELL_SHIFT;
    end else if (commit_ok || state == ST_FULL) begin
      tbl_ctrl.op = CELL_LOAD;
    end else if (state == ST_REMOVE) begin
      tbl_ctrl.op = CELL_REMOVE;
    end else begin
      tbl_ctrl.op = CELL_HOLD;
    end

    bld_ctrl.drop_src = src_r;
    bld_ctrl.query    = pos_r;
    bld_ctrl.op       = mpush ? CELL_SHIFT : CELL_HOLD;

    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (state == ST_FULL) begin
        tbl_load[i] = (i == 0) ? full_ent : '0;
      end else begin
        tbl_load[i] = bld[i];
      end
    end

    found = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit[i]) begin
        found = found | tbl[i].source;
      end
    end

    for (int i = 0; i < MAX_ENTRIES; i++) begin
      vmask[i] = tbl[i].valid;
    end
  end

  // table ring and build row
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cells
    localparam int NXT = (i + 1) % MAX_ENTRIES;
    entry_t bld_nbr;

    assign bld_nbr = (i == MAX_ENTRIES - 1) ? mpush_ent : bld[NXT];

    ipm_cell u_tbl (
      .clk  (clk),
      .rst  (rst),
      .ctrl (tbl_ctrl),
      .nbr  (tbl[NXT]),
      .load (tbl_load[i]),
      .ent  (tbl[i]),
      .hit  (hit[i])
    );

    ipm_cell u_bld (
      .clk  (clk),
      .rst  (rst),
      .ctrl (bld_ctrl),
      .nbr  (bld_nbr),
      .load (bld[i]),
      .ent  (bld[i]),
      .hit  (bld_hit[i])
    );
  end

  ipm_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .start    (mstart),
    .flush    (mflush),
    .piece    (piece),
    .push     (mpush),
    .push_ent (mpush_ent)
  );

  // sequencer
  always_ff @(posedge clk) begin
    entry_t piece_next;
    if (rst) begin
      state       <= ST_IDLE;
      held        <= '0;
      rsp_valid   <= 1'b0;
      piece.valid <= 1'b0;
      push_cnt    <= '0;
      m_cnt       <= '0;
      ent         <= '0;
      phase       <= '0;
      placed      <= 1'b0;
    end else begin
      piece_next       = piece;
      piece_next.valid = 1'b0;
      if (rsp_valid && rsp_ready && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end

      if (mpush) begin
        if (32'(push_cnt) <= MAX_ENTRIES) begin
          push_cnt <= push_cnt + 1'b1;
        end
        if (mpush_ent.valid && 32'(m_cnt) <= MAX_ENTRIES) begin
          m_cnt <= m_cnt + 1'b1;
        end
      end

      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            pos_r      <= req.position;
            span_r     <= req.span;
            pend       <= req_end[POS_BITS-1:0];
            src_r      <= req.source_index;
            res_status <= STAT_OK;
            res_found  <= '0;
            push_cnt   <= '0;
            m_cnt      <= '0;
            ent        <= '0;
            phase      <= '0;
            placed     <= 1'b0;
            case (mode_t'(req.mode))
              MODE_PAINT: begin
                if (bad_src) begin
                  res_status <= STAT_BAD_SRC;
                  state      <= ST_DONE;
                end else if (req.span == '0) begin
                  res_status <= STAT_ZERO_LEN;
                  state      <= ST_DONE;
                end else if (req_end[POS_BITS]) begin
                  res_status <= STAT_END_OVF;
                  state      <= ST_DONE;
                end else begin
                  state <= ST_PAINT;
                end
              end
              MODE_LOOKUP: state <= ST_LOOK;
              MODE_REMOVE: begin
                if (bad_src) begin
                  res_status <= STAT_BAD_SRC;
                  state      <= ST_DONE;
                end else begin
                  state <= ST_REMOVE;
                end
              end
              MODE_FULL: state <= ST_FULL;
              default:   state <= ST_DONE;
            endcase
          end
        end
        ST_LOOK:     state <= ST_LOOK_SUM;
        ST_LOOK_SUM: begin
          res_found <= found;
          state     <= ST_DONE;
        end
        ST_REMOVE:   state <= ST_DONE;
        ST_FULL: begin
          held  <= (folder_length != '0) ? CNT_W'(1) : '0;
          state <= ST_DONE;
        end
        ST_PAINT: begin
          if (32'(ent) == MAX_ENTRIES) begin
            // paint lies past every held interval
            if (!placed) begin
              piece_next = new_piece;
              placed     <= 1'b1;
            end
            state <= ST_DRAIN;
          end else if (!head.valid) begin
            ent <= ent + 1'b1;
          end else begin
            case (phase)
              2'd0: begin
                e_reg <= {1'b0, head.start} + {1'b0, head.length};
                if (!placed && head.start >= pos_r) begin
                  piece_next = new_piece;
                  placed     <= 1'b1;
                end
                phase <= 2'd1;
              end
              2'd1: begin
                if (!ovl) begin
                  piece_next = head;
                end else if (head.start < pos_r) begin
                  piece_next.valid  = 1'b1;
                  piece_next.start  = head.start;
                  piece_next.length = pos_r - head.start;
                  piece_next.source = head.source;
                end
                phase <= 2'd2;
              end
              2'd2: begin
                if (ovl && head.start < pos_r) begin
                  piece_next = new_piece;
                  placed     <= 1'b1;
                end
                phase <= 2'd3;
              end
              default: begin
                // right remainder of an interval cut by the paint
                if (ovl && e_reg > {1'b0, pend}) begin
                  piece_next.valid  = 1'b1;
                  piece_next.start  = pend;
                  piece_next.length = POS_BITS'(e_reg - {1'b0, pend});
                  piece_next.source = head.source;
                end
                ent   <= ent + 1'b1;
                phase <= 2'd0;
              end
            endcase
          end
        end
        ST_DRAIN: state <= ST_FLUSH;
        ST_FLUSH: begin
          // pad with empty slots until the first interval reaches cell 0
          if (32'(push_cnt) >= MAX_ENTRIES - 1) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (32'(m_cnt) > MAX_ENTRIES) begin
            res_status <= STAT_FULL;
          end else begin
            held <= m_cnt;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.found_source <= res_found;
            rsp.entry_count  <= COUNT_W'(held);
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      piece <= piece_next;
    end
  end

  `IPM_ASSERT_IMPL(a_valid_prefix, clk, rst, state == ST_IDLE, (vmask & (vmask + 1'b1)) == '0, "valid cells are not a prefix of the table")
  `IPM_ASSERT_IMPL(a_held_matches, clk, rst, state == ST_IDLE, $countones(vmask) == 32'(held), "held count disagrees with valid cells")
  `IPM_ASSERT_NEXT(a_full_keeps, clk, rst, state == ST_COMMIT && 32'(m_cnt) > MAX_ENTRIES, $stable(held), "rejected paint changed the held count")

endmodule

// File: tb/sv/testbench.sv
// testbench of the interval paint map: predicts every result and checks it field by field
module testbench;
  import ipm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  localparam logic [3:0] ADDR_SOURCE_COUNT  = 4'd0;
  localparam logic [3:0] ADDR_FOLDER_LENGTH = 4'd8;
  localparam logic [39:0] POS_MAX = 40'hFF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 120;

  interval_paint_map_top i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the interval table and the registers
  logic [39:0] map_start [MAX_ENTRIES];
  logic [39:0] map_len   [MAX_ENTRIES];
  logic [3:0]  map_src   [MAX_ENTRIES];
  int          map_count;
  logic [4:0]  src_count_reg;
  logic [39:0] folder_len_reg;

  req_t pending_items[$];
  rsp_t expected_results[$];
  int   errors = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_req = 0;
  bit   hold_done = 0;

  function automatic int source_limit();
    return (src_count_reg < MAX_SOURCES) ? int'(src_count_reg) : MAX_SOURCES;
  endfunction

  function automatic status_t paint_map(logic [39:0] pos, logic [39:0] len, logic [3:0] src);
    logic [40:0] ts [MAX_ENTRIES+2];
    logic [40:0] tl [MAX_ENTRIES+2];
    logic [3:0]  tc [MAX_ENTRIES+2];
    logic [40:0] ms [MAX_ENTRIES+2];
    logic [40:0] ml [MAX_ENTRIES+2];
    logic [3:0]  mc [MAX_ENTRIES+2];
    logic [40:0] s, l, e, stop;
    logic [3:0]  c;
    int n, m;
    bit placed;
    n = 0;
    m = 0;
    placed = 0;
    if (int'(src) >= source_limit()) return STAT_BAD_SRC;
    if (len == 0) return STAT_ZERO_LEN;
    stop = {1'b0, pos} + {1'b0, len};
    if (stop > {1'b0, POS_MAX}) return STAT_END_OVF;
    for (int i = 0; i < map_count; i++) begin
      s = {1'b0, map_start[i]};
      l = {1'b0, map_len[i]};
      c = map_src[i];
      e = s + l;
      if (!placed && s >= pos) begin
        ts[n] = pos; tl[n] = len; tc[n] = src; n++;
        placed = 1;
      end
      if (e <= pos || s >= stop) begin
        ts[n] = s; tl[n] = l; tc[n] = c; n++;
      end else begin
        // overlapped interval: keep the pieces outside the painted range
        if (s < pos) begin
          ts[n] = s; tl[n] = pos - s; tc[n] = c; n++;
          ts[n] = pos; tl[n] = len; tc[n] = src; n++;
          placed = 1;
        end
        if (e > stop) begin
          ts[n] = stop; tl[n] = e - stop; tc[n] = c; n++;
        end
      end
    end
    if (!placed) begin
      ts[n] = pos; tl[n] = len; tc[n] = src; n++;
    end
    for (int i = 0; i < n; i++) begin
      if (m > 0 && ms[m-1] + ml[m-1] == ts[i] && mc[m-1] == tc[i]) begin
        ml[m-1] += tl[i];
      end else begin
        ms[m] = ts[i]; ml[m] = tl[i]; mc[m] = tc[i]; m++;
      end
    end
    if (m > MAX_ENTRIES) return STAT_FULL;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      map_start[i] = (i < m) ? ms[i][39:0] : '0;
      map_len[i]   = (i < m) ? ml[i][39:0] : '0;
      map_src[i]   = (i < m) ? mc[i] : '0;
    end
    map_count = m;
    return STAT_OK;
  endfunction

  function automatic rsp_t apply_item(req_t r);
    rsp_t res;
    res = '0;
    case (mode_t'(r.mode))
      MODE_PAINT: begin
        res.status = paint_map(r.position, r.span, r.source_index);
      end
      MODE_LOOKUP: begin
        for (int i = 0; i < map_count; i++) begin
          if (r.position >= map_start[i] &&
              {1'b0, r.position} < {1'b0, map_start[i]} + {1'b0, map_len[i]}) begin
            res.found_source = map_src[i];
            break;
          end
        end
      end
      MODE_REMOVE: begin
        if (int'(r.source_index) >= source_limit()) begin
          res.status = STAT_BAD_SRC;
        end else begin
          for (int i = 0; i < map_count; i++) begin
            if (map_src[i] == r.source_index) map_src[i] = '0;
            else if (map_src[i] > r.source_index) map_src[i] = map_src[i] - 1'b1;
          end
        end
      end
      default: begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          map_start[i] = '0;
          map_len[i] = '0;
          map_src[i] = '0;
        end
        map_count = 0;
        if (folder_len_reg != 0) begin
          map_len[0] = folder_len_reg;
          map_count = 1;
        end
      end
    endcase
    res.entry_count = map_count[COUNT_W-1:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap <= 0;
    end else if (!req_valid || req_ready) begin
      if (send_gap > 0) begin
        req_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
        req <= pending_items.pop_front();
        req_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1;
      hold_left <= 600;
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left <= pick_gap();
    end
  end

  // monitor: check results, then predict the item taken at this edge
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          exp_rsp = expected_results.pop_front();
          if (rsp.status !== exp_rsp.status) begin
            $error("status expected %0d actual %0d", exp_rsp.status, rsp.status);
            errors++;
          end
          if (rsp.found_source !== exp_rsp.found_source) begin
            $error("found_source expected %0d actual %0d", exp_rsp.found_source,
                   rsp.found_source);
            errors++;
          end
          if (rsp.entry_count !== exp_rsp.entry_count) begin
            $error("entry_count expected %0d actual %0d", exp_rsp.entry_count,
                   rsp.entry_count);
            errors++;
          end
        end
      end
      if (req_valid && req_ready) expected_results = {expected_results, apply_item(req)};
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [3:0] addr, logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_SOURCE_COUNT) src_count_reg = data[4:0];
    else folder_len_reg = data[39:0];
  endtask

  task automatic set_config(logic [4:0] sources, logic [39:0] folder);
    reg_write(ADDR_SOURCE_COUNT, {59'd0, sources});
    reg_write(ADDR_FOLDER_LENGTH, {24'd0, folder});
  endtask

  task automatic add_item(mode_t md, logic [39:0] pos, logic [39:0] len, logic [3:0] src);
    req_t r;
    r.mode = md;
    r.position = pos;
    r.span = len;
    r.source_index = src;
    pending_items = {pending_items, r};
  endtask

  task automatic add_random_items(int count);
    int k;
    mode_t md;
    logic [39:0] pos, len;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      md = (k < 55) ? MODE_PAINT : (k < 80) ? MODE_LOOKUP : (k < 90) ? MODE_REMOVE : MODE_FULL;
      k = $urandom_range(0, 99);
      if (k < 85) pos = 40'($urandom_range(0, 240));
      else if (k < 95) pos = 40'({$urandom, $urandom});
      else pos = POS_MAX - 40'($urandom_range(0, 60));
      k = $urandom_range(0, 99);
      if (k < 85) len = 40'($urandom_range(1, 40));
      else if (k < 90) len = '0;
      else len = 40'({$urandom, $urandom});
      add_item(md, pos, len, 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    src_count_reg = '0;
    folder_len_reg = '0;
    map_count = 0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      map_start[i] = '0;
      map_len[i] = '0;
      map_src[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_config(5'd16, 40'd1000);
    add_item(MODE_LOOKUP, 40'd5, 40'd0, 4'd0);
    add_item(MODE_FULL, 40'd0, 40'd0, 4'd0);
    add_item(MODE_LOOKUP, 40'd500, 40'd0, 4'd0);
    add_item(MODE_PAINT, 40'd100, 40'd50, 4'd3);
    add_item(MODE_LOOKUP, 40'd120, 40'd0, 4'd0);
    // adjacent paint with the same source merges
    add_item(MODE_PAINT, 40'd150, 40'd10, 4'd3);
    add_item(MODE_PAINT, 40'd130, 40'd5, 4'd15);
    add_item(MODE_PAINT, 40'd5, 40'd0, 4'd1);
    add_item(MODE_PAINT, POS_MAX, 40'd1, 4'd1);
    add_item(MODE_PAINT, 40'd0, POS_MAX, 4'd2);
    add_item(MODE_LOOKUP, POS_MAX, 40'd0, 4'd0);
    add_item(MODE_REMOVE, 40'd0, 40'd0, 4'd2);
    add_item(MODE_FULL, 40'd0, 40'd0, 4'd0);
    // alternating slivers until the table overflows
    for (int k = 0; k < 9; k++) add_item(MODE_PAINT, 40'(10 * k + 3), 40'd1, 4'(k + 4));
    add_item(MODE_REMOVE, 40'd0, 40'd0, 4'd5);
    wait_idle();

    set_config(5'd4, 40'd0);
    add_item(MODE_PAINT, 40'd10, 40'd10, 4'd9);
    add_item(MODE_REMOVE, 40'd0, 40'd0, 4'd9);
    add_item(MODE_FULL, 40'd0, 40'd0, 4'd0);
    add_item(MODE_LOOKUP, 40'd0, 40'd0, 4'd0);
    wait_idle();

    set_config(5'd31, POS_MAX);
    hold_req = 1;
    add_random_items(140);
    wait_idle();
    set_config(5'd0, 40'd0);
    add_random_items(40);
    wait_idle();
    set_config(5'($urandom_range(2, 16)), 40'($urandom_range(1, 300)));
    add_random_items(130);
    wait_idle();
    set_config(5'd16, 40'($urandom_range(100, 250)));
    add_random_items(130);
    wait_idle();
    set_config(5'($urandom_range(1, 31)), 40'({$urandom, $urandom}));
    add_random_items(110);
    wait_idle();

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: interval_paint_map_top.f
+incdir+sv
sv/ipm_pkg.sv
sv/ipm_cell.sv
sv/ipm_merge.sv
sv/interval_paint_map_top.sv
tb/sv/testbench.sv
